// File: rtl/core/hrs_pkg.sv
// Shared types, constants and prefix tables of the HTTP request header scanner.
package hrs_pkg;

    localparam int MAX_HEADER_BYTES = 4096;
    // Byte offsets run up to MAX_HEADER_BYTES; the agent start may reach one beyond it.
    localparam int POS_W = $clog2(MAX_HEADER_BYTES + 1);
    localparam int OFS_W = $clog2(MAX_HEADER_BYTES + 2);

    localparam int BYTE_W   = 8;
    localparam int START_W  = 12;
    localparam int LEN_W    = 13;
    localparam int START_MAX = 4095;
    localparam int LEN_MAX   = 8191;
    localparam int IN_TDATA_W = 8;
    localparam int RES_W      = 80;

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [OFS_W-1:0] t_ofs;

    // Line phases
    localparam logic [1:0] PH_FIRST       = 2'd0;
    localparam logic [1:0] PH_SECOND      = 2'd1;
    localparam logic [1:0] PH_LATER       = 2'd2;
    localparam logic [1:0] PH_AFTER_EMPTY = 2'd3;

    // Method codes
    localparam logic [1:0] M_UNKNOWN = 2'd0;
    localparam logic [1:0] M_GET     = 2'd1;
    localparam logic [1:0] M_HEAD    = 2'd2;

    // Flag bit positions
    localparam int FLAG_PATH  = 0;
    localparam int FLAG_HOST  = 1;
    localparam int FLAG_AGENT = 2;

    // Held offset slots
    localparam int OFS_PATH_START  = 0;
    localparam int OFS_PATH_LEN    = 1;
    localparam int OFS_HOST_START  = 2;
    localparam int OFS_HOST_LEN    = 3;
    localparam int OFS_AGENT_START = 4;
    localparam int OFS_AGENT_LEN   = 5;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // Prefix strings, left aligned in 16 byte slots so any 4-bit index is in range.
    localparam logic [127:0] TXT_GET   = {"GET", 104'h0};
    localparam logic [127:0] TXT_HEAD  = {"HEAD", 96'h0};
    localparam logic [127:0] TXT_HOST  = {"Host:", 88'h0};
    localparam logic [127:0] TXT_AGENT = {"User-Agent:", 40'h0};

    typedef struct packed {
        t_pos             pos;
        logic [1:0]       phase;
        logic [1:0]       chars;      // characters in line, saturating at two
        logic [1:0]       tok_num;
        logic             in_tok;
        logic [3:0]       prog;
        logic [1:0]       alive;
        logic             done;
        logic [1:0]       method;
        logic [5:0][OFS_W-1:0] ofs;
        logic [2:0]       flags;
        logic             muted;
        logic             host_armed;
    } t_scan;

    // Packed so that the last field sits in the lowest bits.
    typedef struct packed {
        logic [LEN_W-1:0]   agent_length;
        logic [START_W-1:0] agent_start;
        logic               agent_found;
        logic [LEN_W-1:0]   host_length;
        logic [START_W-1:0] host_start;
        logic               host_found;
        logic [LEN_W-1:0]   path_length;
        logic [START_W-1:0] path_start;
        logic [1:0]         method_code;
        logic               path_ok;
    } t_result;

    function automatic logic [127:0] pfx_text(input logic [1:0] phase, input logic k);
        logic [127:0] txt;
        case (phase)
            PH_FIRST:  txt = k ? TXT_HEAD : TXT_GET;
            PH_SECOND: txt = TXT_HOST;
            default:   txt = TXT_AGENT;
        endcase
        return txt;
    endfunction

    function automatic logic [3:0] pfx_len(input logic [1:0] phase, input logic k);
        logic [3:0] len;
        case (phase)
            PH_FIRST:  len = k ? 4'd4 : 4'd3;
            PH_SECOND: len = 4'd5;
            default:   len = 4'd11;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] pfx_char(input logic [1:0] phase, input logic k,
                                            input logic [3:0] idx);
        logic [127:0] txt;
        txt = pfx_text(phase, k);
        return txt[127 - 8 * idx -: 8];
    endfunction

endpackage

// File: rtl/core/hrs_scan.sv
// Per-byte scanning state and the combinational update that produces the result.
module hrs_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    output hrs_pkg::t_result     o_result
);
    import hrs_pkg::*;

    t_scan r_state;
    t_scan n_state;
    t_scan s_work;

    function automatic logic hit(input t_scan s, input logic k);
        return s.alive[k] && (s.prog >= pfx_len(s.phase, k));
    endfunction

    function automatic t_scan tok_begin(input t_scan s, input t_ofs pos);
        t_scan r;
        r = s;
        r.in_tok = 1'b1;
        r.prog   = 4'd0;
        r.alive  = 2'b00;
        if (s.tok_num != 2'd3) begin
            r.tok_num = s.tok_num + 2'd1;
        end
        if (r.phase == PH_FIRST && r.tok_num == 2'd1) begin
            r.alive = 2'b11;
        end else if (r.phase == PH_FIRST && r.tok_num == 2'd2) begin
            r.ofs[OFS_PATH_START] = pos + t_ofs'(1);
        end else if (r.phase == PH_SECOND && r.tok_num == 2'd1) begin
            r.alive = 2'b01;
        end else if (r.phase == PH_SECOND && r.tok_num == 2'd2 && r.host_armed) begin
            r.ofs[OFS_HOST_START] = pos;
        end else if (r.phase[1]) begin
            r.alive = 2'b01;
        end
        return r;
    endfunction

    function automatic t_scan tok_feed(input t_scan s, input logic [7:0] b);
        t_scan r;
        r = s;
        for (int k = 0; k < 2; k++) begin
            if (s.alive[k[0]] && s.prog < pfx_len(s.phase, k[0])
                && pfx_char(s.phase, k[0], s.prog) != b) begin
                r.alive[k[0]] = 1'b0;
            end
        end
        if (s.prog != 4'd15) begin
            r.prog = s.prog + 4'd1;
        end
        return r;
    endfunction

    function automatic t_scan tok_finish(input t_scan s, input t_ofs t);
        t_scan r;
        r = s;
        if (s.in_tok) begin
            r.in_tok = 1'b0;
            if (s.phase == PH_FIRST && s.tok_num == 2'd1) begin
                r.method = hit(s, 1'b0) ? M_GET : (hit(s, 1'b1) ? M_HEAD : M_UNKNOWN);
            end else if (s.phase == PH_FIRST && s.tok_num == 2'd2) begin
                r.flags[FLAG_PATH]  = 1'b1;
                r.ofs[OFS_PATH_LEN] = t - s.ofs[OFS_PATH_START];
            end else if (s.phase == PH_SECOND && s.tok_num == 2'd1) begin
                r.host_armed = hit(s, 1'b0);
            end else if (s.phase == PH_SECOND && s.tok_num == 2'd2) begin
                if (s.host_armed) begin
                    r.flags[FLAG_HOST]  = 1'b1;
                    r.ofs[OFS_HOST_LEN] = t - s.ofs[OFS_HOST_START];
                end
            end else if (s.phase[1] && hit(s, 1'b0)) begin
                r.flags[FLAG_AGENT]    = 1'b1;
                r.ofs[OFS_AGENT_START] = t + t_ofs'(1);
                r.muted                = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic t_scan line_close(input t_scan s, input t_ofs e);
        t_scan r;
        r = tok_finish(s, e);
        if (r.phase == PH_FIRST) begin
            if (!r.flags[FLAG_PATH]) begin
                r.done = 1'b1;
            end else begin
                r.phase = PH_SECOND;
            end
        end else if (r.phase == PH_SECOND) begin
            if (r.tok_num == 2'd0) begin
                r.done = 1'b1;
            end else begin
                r.phase = PH_LATER;
            end
        end else if (r.flags[FLAG_AGENT]) begin
            r.ofs[OFS_AGENT_LEN] = (e > r.ofs[OFS_AGENT_START])
                                 ? e - r.ofs[OFS_AGENT_START] : '0;
            r.done = 1'b1;
        end else begin
            r.phase = (r.chars == 2'd0) ? PH_AFTER_EMPTY : PH_LATER;
        end
        r.chars      = 2'd0;
        r.tok_num    = 2'd0;
        r.in_tok     = 1'b0;
        r.prog       = 4'd0;
        r.alive      = 2'b00;
        r.muted      = 1'b0;
        r.host_armed = 1'b0;
        return r;
    endfunction

    function automatic t_scan take_byte(input t_scan s, input logic [7:0] b, input t_ofs pos);
        t_scan r;
        r = s;
        if (b == CH_LF) begin
            if (s.chars == 2'd1 || (s.chars == 2'd0 && s.phase == PH_AFTER_EMPTY)) begin
                r.done = 1'b1;
            end else begin
                r = line_close(s, pos);
            end
        end else if (s.chars == 2'd0 && pos != '0 && b == CH_NUL) begin
            r.done = 1'b1;
        end else begin
            if (s.chars != 2'd2) begin
                r.chars = s.chars + 2'd1;
            end
            if (!s.muted) begin
                if (b == CH_NUL) begin
                    r = tok_finish(r, pos);
                    r.muted = 1'b1;
                end else if (b == CH_SPACE) begin
                    r = tok_finish(r, pos);
                end else begin
                    if (!r.in_tok) begin
                        r = tok_begin(r, pos);
                    end
                    r = tok_feed(r, b);
                end
            end
        end
        return r;
    endfunction

    function automatic logic [START_W-1:0] cap_start(input t_ofs v);
        return (32'(v) > 32'(START_MAX)) ? START_W'(START_MAX) : START_W'(v);
    endfunction

    function automatic logic [LEN_W-1:0] cap_len(input t_ofs v);
        return (32'(v) > 32'(LEN_MAX)) ? LEN_W'(LEN_MAX) : LEN_W'(v);
    endfunction

    always_comb begin
        s_work = r_state;
        if (32'(r_state.pos) < 32'(MAX_HEADER_BYTES)) begin
            if (!r_state.done) begin
                s_work = take_byte(r_state, i_byte, t_ofs'(r_state.pos));
            end
            s_work.pos = r_state.pos + t_pos'(1);
        end
        if (i_last && !s_work.done && s_work.chars != 2'd0) begin
            s_work = line_close(s_work, t_ofs'(s_work.pos));
        end
    end

    always_comb begin
        o_result.path_ok      = s_work.flags[FLAG_PATH];
        o_result.method_code  = s_work.method;
        o_result.path_start   = s_work.flags[FLAG_PATH]
                              ? cap_start(s_work.ofs[OFS_PATH_START]) : '0;
        o_result.path_length  = s_work.flags[FLAG_PATH]
                              ? cap_len(s_work.ofs[OFS_PATH_LEN]) : '0;
        o_result.host_found   = s_work.flags[FLAG_HOST];
        o_result.host_start   = s_work.flags[FLAG_HOST]
                              ? cap_start(s_work.ofs[OFS_HOST_START]) : '0;
        o_result.host_length  = s_work.flags[FLAG_HOST]
                              ? cap_len(s_work.ofs[OFS_HOST_LEN]) : '0;
        o_result.agent_found  = s_work.flags[FLAG_AGENT];
        o_result.agent_start  = s_work.flags[FLAG_AGENT]
                              ? cap_start(s_work.ofs[OFS_AGENT_START]) : '0;
        o_result.agent_length = s_work.flags[FLAG_AGENT]
                              ? cap_len(s_work.ofs[OFS_AGENT_LEN]) : '0;
    end

    // After the last byte of a buffer the scanner starts afresh.
    always_comb begin
        n_state = r_state;
        if (i_step) begin
            n_state = i_last ? '0 : s_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: rtl/core/http_request_header_scanner_core.sv
// Result path: a word carrying tlast waits in the word register until the result register has room;
// its result is then registered there and shown on m_tdata; the scanner state is updated combinationally per byte.
// Throughput: one header byte per cycle, except that a word closing a buffer waits while the result register
// is full; bytes of a buffer keep flowing while a finished result waits to be taken.
// Reset: synchronous, active low; it empties both registers and clears the scanner state.
// Top level of the HTTP request header scanner.
module http_request_header_scanner_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [hrs_pkg::IN_TDATA_W-1:0] s_tdata,  // [7:0] byte_value
    input  logic                       s_tlast,      // final_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // m_tdata from bit 0 up: path_ok, method_code, path_start, path_length,
    // host_found, host_start, host_length, agent_found, agent_start, agent_length
    output logic [hrs_pkg::RES_W-1:0]  m_tdata
);
    import hrs_pkg::*;

    // Input word register: one header byte and its end-of-buffer mark.
    logic             r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic             r_in_last;

    // Result register.
    logic             r_out_valid;
    t_result          r_out_data;

    t_result          scan_result;
    logic             out_free;
    logic             step;

    // The result register can take a new result when it is empty or being drained.
    assign out_free = !r_out_valid || m_tready;
    // A held word that closes a buffer needs room in the result register; any other
    // word is consumed straight away.
    assign step     = r_in_valid && (!r_in_last || out_free);
    assign s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tready) begin
            r_in_valid <= s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tready && s_tvalid) begin
            r_in_byte <= s_tdata[BYTE_W-1:0];
            r_in_last <= s_tlast;
        end
    end

    hrs_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_result (scan_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out_data <= scan_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

// File: rtl/core/hrs_checker.sv
// Port-level checks of the header scanner and the bind that attaches them.
module hrs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata
);

    // No result may be shown in the cycle after reset, and the input side is open.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid && s_tready)
        else $error("result shown or input closed straight after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Only unknown, GET and HEAD are reported.
    a_method: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[2:1] != 2'd3)
        else $error("method code out of range");

    // Without a path the path offset and length are zero.
    a_path_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[27:3] == 25'd0)
        else $error("path fields set without a path");

    // Without an agent token the agent offset and length are zero.
    a_agent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tdata[54] |-> m_tdata[79:55] == 25'd0)
        else $error("agent fields set without an agent");

endmodule

bind http_request_header_scanner_core hrs_checker u_hrs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: bench/tb_http_request_header_scanner_core.sv
// Testbench for the header scanner core: streams request buffers and checks each result word against a built-in scan model.
module tb_http_request_header_scanner_core;
    timeunit 1ns;
    timeprecision 1ps;

    import hrs_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [7:0] CR_BYTE = 8'h0D;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_TDATA_W-1:0] s_tdata;   // [7:0] byte_value
    logic                  s_tlast;   // final_byte
    logic                  m_tvalid;
    logic                  m_tready;
    // m_tdata from bit 0 up: path_ok, method_code, path_start, path_length,
    // host_found, host_start, host_length, agent_found, agent_start, agent_length
    logic [RES_W-1:0]      m_tdata;

    http_request_header_scanner_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Scan model state, one copy of everything the block keeps per buffer.
    int unsigned scan_pos;
    int unsigned scan_chars;
    logic [1:0]  scan_phase;
    logic [1:0]  scan_tok_num;
    logic        scan_in_tok;
    logic [3:0]  scan_prog;
    logic [1:0]  scan_alive;
    logic        scan_done;
    logic [1:0]  scan_method;
    int unsigned scan_ofs [6];
    logic [2:0]  scan_flags;
    logic        scan_muted;
    logic        scan_host_armed;

    t_result     expected_headers [$];
    logic [7:0]  frame_bytes [$];

    int fault_count   = 0;
    int result_count  = 0;
    int cycle_count   = 0;
    int idle_span_max = 0;
    int burst_left    = 0;
    int hold_asked    = 0;
    int bytes_sent    = 0;
    int frames_sent   = 0;

    // ------------------------------------------------------------------
    // Scan model
    // ------------------------------------------------------------------
    function automatic string prefix_text(input logic [1:0] phase, input bit k);
        if (phase == PH_FIRST) return k ? "HEAD" : "GET";
        if (phase == PH_SECOND) return "Host:";
        return "User-Agent:";
    endfunction

    function automatic bit prefix_hit(input bit k);
        string p;
        p = prefix_text(scan_phase, k);
        return scan_alive[k] && (scan_prog >= p.len());
    endfunction

    function automatic int unsigned cap_to(input int unsigned v, input int unsigned lim);
        return (v > lim) ? lim : v;
    endfunction

    function automatic void scan_reset();
        scan_pos        = 0;
        scan_chars      = 0;
        scan_phase      = PH_FIRST;
        scan_tok_num    = 2'd0;
        scan_in_tok     = 1'b0;
        scan_prog       = 4'd0;
        scan_alive      = 2'b00;
        scan_done       = 1'b0;
        scan_method     = M_UNKNOWN;
        foreach (scan_ofs[i]) scan_ofs[i] = 0;
        scan_flags      = 3'b000;
        scan_muted      = 1'b0;
        scan_host_armed = 1'b0;
    endfunction

    function automatic void token_open(input int unsigned pos);
        scan_in_tok = 1'b1;
        scan_prog   = 4'd0;
        scan_alive  = 2'b00;
        if (scan_tok_num < 2'd3) scan_tok_num++;
        if (scan_phase == PH_FIRST && scan_tok_num == 2'd1)
            scan_alive = 2'b11;
        else if (scan_phase == PH_FIRST && scan_tok_num == 2'd2)
            scan_ofs[OFS_PATH_START] = pos + 1;
        else if (scan_phase == PH_SECOND && scan_tok_num == 2'd1)
            scan_alive = 2'b01;
        else if (scan_phase == PH_SECOND && scan_tok_num == 2'd2 && scan_host_armed)
            scan_ofs[OFS_HOST_START] = pos;
        else if (scan_phase >= PH_LATER)
            scan_alive = 2'b01;
    endfunction

    function automatic void token_feed(input logic [7:0] b);
        string p;
        for (int k = 0; k < 2; k++) begin
            if (scan_alive[k[0]]) begin
                p = prefix_text(scan_phase, k == 1);
                if (scan_prog < p.len() && p[scan_prog] != b) scan_alive[k[0]] = 1'b0;
            end
        end
        if (scan_prog < 4'd15) scan_prog++;
    endfunction

    function automatic void token_close(input int unsigned t);
        if (!scan_in_tok) return;
        scan_in_tok = 1'b0;
        if (scan_phase == PH_FIRST && scan_tok_num == 2'd1) begin
            scan_method = prefix_hit(0) ? M_GET : (prefix_hit(1) ? M_HEAD : M_UNKNOWN);
        end else if (scan_phase == PH_FIRST && scan_tok_num == 2'd2) begin
            scan_flags[FLAG_PATH]  = 1'b1;
            scan_ofs[OFS_PATH_LEN] = t - scan_ofs[OFS_PATH_START];
        end else if (scan_phase == PH_SECOND && scan_tok_num == 2'd1) begin
            scan_host_armed = prefix_hit(0);
        end else if (scan_phase == PH_SECOND && scan_tok_num == 2'd2) begin
            if (scan_host_armed) begin
                scan_flags[FLAG_HOST]  = 1'b1;
                scan_ofs[OFS_HOST_LEN] = t - scan_ofs[OFS_HOST_START];
            end
        end else if (scan_phase >= PH_LATER && prefix_hit(0)) begin
            scan_flags[FLAG_AGENT]    = 1'b1;
            scan_ofs[OFS_AGENT_START] = t + 1;
            scan_muted                = 1'b1;
        end
    endfunction

    function automatic void line_end(input int unsigned e);
        token_close(e);
        if (scan_phase == PH_FIRST) begin
            if (!scan_flags[FLAG_PATH]) scan_done = 1'b1;
            else scan_phase = PH_SECOND;
        end else if (scan_phase == PH_SECOND) begin
            if (scan_tok_num == 2'd0) scan_done = 1'b1;
            else scan_phase = PH_LATER;
        end else if (scan_flags[FLAG_AGENT]) begin
            scan_ofs[OFS_AGENT_LEN] = (e > scan_ofs[OFS_AGENT_START]) ?
                                      e - scan_ofs[OFS_AGENT_START] : 0;
            scan_done = 1'b1;
        end else begin
            scan_phase = (scan_chars == 0) ? PH_AFTER_EMPTY : PH_LATER;
        end
        scan_chars      = 0;
        scan_tok_num    = 2'd0;
        scan_in_tok     = 1'b0;
        scan_prog       = 4'd0;
        scan_alive      = 2'b00;
        scan_muted      = 1'b0;
        scan_host_armed = 1'b0;
    endfunction

    function automatic void scan_take(input logic [7:0] b, input int unsigned pos);
        if (b == CH_LF) begin
            // A one-byte line, or a second empty line in a row, ends the header.
            if (scan_chars == 1 || (scan_chars == 0 && scan_phase == PH_AFTER_EMPTY))
                scan_done = 1'b1;
            else
                line_end(pos);
            return;
        end
        if (scan_chars == 0 && pos > 0 && b == CH_NUL) begin
            scan_done = 1'b1;
            return;
        end
        if (scan_chars < LEN_MAX) scan_chars++;
        if (scan_muted) return;
        if (b == CH_NUL) begin
            token_close(pos);
            scan_muted = 1'b1;
            return;
        end
        if (b == CH_SPACE) begin
            token_close(pos);
            return;
        end
        if (!scan_in_tok) token_open(pos);
        token_feed(b);
    endfunction

    // Advances the model by one accepted word; the final byte yields the expected result.
    function automatic void scan_header_byte(input logic [7:0] b, input logic last);
        t_result want;
        if (scan_pos < MAX_HEADER_BYTES) begin
            if (!scan_done) scan_take(b, scan_pos);
            scan_pos++;
        end
        if (!last) return;
        if (!scan_done && scan_chars > 0) line_end(scan_pos);
        want = '0;
        want.path_ok     = scan_flags[FLAG_PATH];
        want.method_code = scan_method;
        if (scan_flags[FLAG_PATH]) begin
            want.path_start  = START_W'(cap_to(scan_ofs[OFS_PATH_START], START_MAX));
            want.path_length = LEN_W'(cap_to(scan_ofs[OFS_PATH_LEN], LEN_MAX));
        end
        want.host_found = scan_flags[FLAG_HOST];
        if (scan_flags[FLAG_HOST]) begin
            want.host_start  = START_W'(cap_to(scan_ofs[OFS_HOST_START], START_MAX));
            want.host_length = LEN_W'(cap_to(scan_ofs[OFS_HOST_LEN], LEN_MAX));
        end
        want.agent_found = scan_flags[FLAG_AGENT];
        if (scan_flags[FLAG_AGENT]) begin
            want.agent_start  = START_W'(cap_to(scan_ofs[OFS_AGENT_START], START_MAX));
            want.agent_length = LEN_W'(cap_to(scan_ofs[OFS_AGENT_LEN], LEN_MAX));
        end
        expected_headers.push_back(want);
        scan_reset();
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic note_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got) begin
            fault_count++;
            if (fault_count <= 10)
                $display("result %0d: %s expected %0d, got %0d",
                         result_count, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_headers.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("result word %h arrived with nothing expected", m_tdata);
            end else begin
                want = expected_headers.pop_front();
                note_field("path_ok",      want.path_ok,      got.path_ok);
                note_field("method_code",  want.method_code,  got.method_code);
                note_field("path_start",   want.path_start,   got.path_start);
                note_field("path_length",  want.path_length,  got.path_length);
                note_field("host_found",   want.host_found,   got.host_found);
                note_field("host_start",   want.host_start,   got.host_start);
                note_field("host_length",  want.host_length,  got.host_length);
                note_field("agent_found",  want.agent_found,  got.agent_found);
                note_field("agent_start",  want.agent_start,  got.agent_start);
                note_field("agent_length", want.agent_length, got.agent_length);
            end
            result_count++;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("http_request_header_scanner_core verification failed");
            $finish;
        end
    end

    // Result side: tready follows one of four patterns, picked again at random as the run goes on,
    // and a requested hold keeps tready low for a long stretch.
    initial begin
        int         hold_left;
        int         hold_taken;
        int         mode;
        int         mode_left;
        logic [15:0] mask;
        hold_left  = 0;
        hold_taken = 0;
        mode       = 0;
        mode_left  = 0;
        mask       = 16'hFFFF;
        m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_taken) begin
                hold_taken = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 80);
                mask      = 16'($urandom) | 16'h0001;
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: begin
                        m_tready <= mask[0];
                        mask = {mask[0], mask[15:1]};
                    end
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sending
    // ------------------------------------------------------------------
    // Offers one word, waits for it to be taken and then perhaps leaves a gap.
    task automatic send_header_byte(input logic [7:0] b, input logic last);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        scan_header_byte(b, last);
        bytes_sent++;
        if (idle_span_max > 0) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap        = $urandom_range(1, idle_span_max);
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_frame();
        int n;
        n = frame_bytes.size();
        for (int i = 0; i < n; i++) send_header_byte(frame_bytes[i], i == n - 1);
        frame_bytes.delete();
        frames_sent++;
    endtask

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
    endfunction

    function automatic void add_line(input string s, input bit with_cr);
        push_text(s);
        if (with_cr) frame_bytes.push_back(CR_BYTE);
        frame_bytes.push_back(CH_LF);
    endfunction

    function automatic logic [7:0] token_char();
        case ($urandom_range(0, 9))
            0:       return CR_BYTE;
            1:       return 8'($urandom_range(8'h80, 8'hFF));
            default: return 8'($urandom_range(8'h21, 8'h7E));
        endcase
    endfunction

    function automatic void push_token(input int n);
        for (int i = 0; i < n; i++) frame_bytes.push_back(token_char());
    endfunction

    function automatic void push_spaces(input int n);
        for (int i = 0; i < n; i++) frame_bytes.push_back(CH_SPACE);
    endfunction

    function automatic void end_line();
        if ($urandom_range(0, 1)) frame_bytes.push_back(CR_BYTE);
        frame_bytes.push_back(CH_LF);
    endfunction

    // A request of the usual shape with random content and the odd near miss.
    function automatic void build_random_request();
        if ($urandom_range(0, 4) == 0) push_spaces($urandom_range(1, 2));
        case ($urandom_range(0, 7))
            0: push_text("GET");
            1: push_text("HEAD");
            2: push_text("GETS");
            3: push_text("HEADER");
            4: push_text("GE");
            5: push_text("HE");
            6: push_text("PUT");
            default: push_token($urandom_range(1, 4));
        endcase
        if ($urandom_range(0, 9) != 0) begin
            push_spaces($urandom_range(1, 3));
            frame_bytes.push_back("/");
            push_token($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) push_text(" H1");
        end
        end_line();
        case ($urandom_range(0, 9))
            0: frame_bytes.push_back(CH_LF);
            1: add_line("H", 0);
            2: begin
                push_text("Hos: ");
                push_token(2);
                end_line();
            end
            3: begin
                push_text("Host:");
                end_line();
            end
            4: begin
                push_text("Host:");
                push_token($urandom_range(1, 3));
                push_text(" v");
                end_line();
            end
            default: begin
                push_text("Host:");
                push_spaces($urandom_range(1, 2));
                push_token($urandom_range(1, 3));
                end_line();
            end
        endcase
        repeat ($urandom_range(0, 2)) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    push_text("User-Agent:");
                    if ($urandom_range(0, 2) == 0) push_token($urandom_range(1, 2));
                    if ($urandom_range(0, 3) != 0) begin
                        push_spaces($urandom_range(1, 2));
                        push_token($urandom_range(0, 3));
                        if ($urandom_range(0, 1)) begin
                            frame_bytes.push_back(CH_SPACE);
                            push_token(2);
                        end
                    end
                    end_line();
                end
                2: begin
                    push_text("X-");
                    push_token($urandom_range(0, 2));
                    push_text(": ");
                    push_token($urandom_range(1, 2));
                    end_line();
                end
                3: end_line();
                4: begin
                    push_text("User-Agen: q");
                    end_line();
                end
                default: begin
                    push_text("User-Agent:");
                    frame_bytes.push_back(CH_NUL);
                    push_token(2);
                    end_line();
                end
            endcase
        end
        if ($urandom_range(0, 1)) frame_bytes.push_back(CH_LF);
    endfunction

    function automatic void build_noise_frame();
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 7))
                0:       frame_bytes.push_back(CH_LF);
                1:       frame_bytes.push_back(CH_SPACE);
                2:       frame_bytes.push_back(CH_NUL);
                3:       frame_bytes.push_back("G");
                4:       frame_bytes.push_back(CR_BYTE);
                default: frame_bytes.push_back(8'($urandom_range(0, 255)));
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_methods_and_fields();
        idle_span_max = 3;
        add_line("GET /index.html HTTP/1.1", 1);
        add_line("Host: example.org", 1);
        add_line("User-Agent: tb agent 1", 1);
        add_line("Accept: x", 1);
        add_line("", 1);
        send_frame();
        add_line("HEAD / ", 0);
        add_line("Host:  h2", 0);
        add_line("", 0);
        send_frame();
        add_line("POST /form", 0);
        add_line("Host: a", 0);
        send_frame();
        // Prefix matches on longer tokens; Host on a later line means nothing.
        add_line("  GETTER   /p  extra", 0);
        add_line("X: y", 0);
        add_line("Host: z", 0);
        add_line("User-Agent:", 0);
        send_frame();
    endtask

    task automatic test_special_lines();
        idle_span_max = 0;
        // One-byte line stops the scan.
        add_line("GET /a", 0);
        add_line("H", 0);
        add_line("Host: x", 0);
        send_frame();
        // Empty line followed by another line feed.
        add_line("GET /a", 0);
        add_line("Host: b", 0);
        add_line("X: y", 0);
        add_line("", 0);
        add_line("", 0);
        add_line("User-Agent: z", 0);
        send_frame();
        // NUL straight after a line feed.
        add_line("GET /a", 0);
        frame_bytes.push_back(CH_NUL);
        add_line("Host: c", 0);
        send_frame();
        // NUL inside a line ends the token and mutes the rest of the line.
        push_text("GET /ab");
        frame_bytes.push_back(CH_NUL);
        add_line("cd", 0);
        push_text("Host:");
        frame_bytes.push_back(CH_NUL);
        add_line(" x", 0);
        send_frame();
        // NUL as the very first byte is not a stop.
        frame_bytes.push_back(CH_NUL);
        add_line("GET /x", 0);
        add_line("Host: y", 0);
        send_frame();
        // First line without a path, then an empty second line.
        add_line("GET", 0);
        add_line("Host: x", 0);
        send_frame();
        add_line("GET /a", 0);
        add_line("", 0);
        add_line("Host: x", 0);
        send_frame();
        // Agent token glued to its text; the scan stops at that line end.
        add_line("GET /a", 1);
        add_line("Host:h h2", 1);
        add_line("User-Agent:mozilla x y", 1);
        add_line("More: z", 1);
        send_frame();
        // Buffers ending without a line feed.
        push_text("GET /abc");
        send_frame();
        add_line("GET /a", 0);
        push_text("Host: hh");
        send_frame();
        add_line("GET /b", 0);
        add_line("Host: h", 0);
        push_text("User-Agent: q r");
        send_frame();
        // Single-word buffers.
        frame_bytes.push_back(8'hFF);
        send_frame();
        frame_bytes.push_back(CH_LF);
        send_frame();
    endtask

    task automatic test_oversized_buffer();
        idle_span_max = 0;
        // Path begins at the last in-range offset; bytes past the limit are dropped.
        push_text("GET");
        while (frame_bytes.size() < MAX_HEADER_BYTES - 2) frame_bytes.push_back(CH_SPACE);
        frame_bytes.push_back("/");
        while (frame_bytes.size() < MAX_HEADER_BYTES + 4) frame_bytes.push_back("p");
        send_frame();
        // Agent token ends exactly at the limit, so its start saturates.
        add_line("GET /x", 0);
        add_line("Host: h", 0);
        while (frame_bytes.size() < MAX_HEADER_BYTES - 11) frame_bytes.push_back(CH_SPACE);
        push_text("User-Agent:");
        push_text("abcd");
        send_frame();
    endtask

    task automatic test_result_backpressure();
        // The result side holds off while the sender keeps offering one-word
        // buffers, so the block fills and must drop s_tready.
        idle_span_max = 0;
        hold_asked++;
        repeat (12) begin
            frame_bytes.push_back("G");
            send_frame();
        end
        repeat (3) begin
            add_line("HEAD /q", 0);
            send_frame();
        end
    endtask

    task automatic test_random_requests();
        int first_frame;
        int first_byte;
        int cut;
        first_frame = frames_sent;
        first_byte  = bytes_sent;
        while (frames_sent - first_frame < 40 || bytes_sent - first_byte < 500) begin
            case ($urandom_range(0, 3))
                0:       idle_span_max = 0;
                1:       idle_span_max = 2;
                default: idle_span_max = 5;
            endcase
            if ($urandom_range(0, 3) == 0) build_noise_frame();
            else build_random_request();
            if ($urandom_range(0, 6) == 0)
                frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] =
                    8'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, frame_bytes.size());
                while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
            end
            send_frame();
        end
    endtask

    initial begin
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        scan_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_methods_and_fields();
        test_special_lines();
        test_oversized_buffer();
        test_result_backpressure();
        test_random_requests();

        s_tvalid <= 1'b0;
        while (expected_headers.size() != 0) @(posedge i_clk);
        // Allow for a stray late word from the two-stage output path.
        repeat (8) @(posedge i_clk);
        if (fault_count == 0) begin
            $display("http_request_header_scanner_core verification clean");
        end else begin
            $display("http_request_header_scanner_core verification failed");
        end
        $finish;
    end

endmodule
